// ===== design/isw_pkg.sv =====
// Shared types and constants for the image sample word packer.
// Holds the word geometry, register indexes, pad table and beat structs.
// No dependencies.
package isw_pkg;

  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned FREE_W      = $clog2(WORD_BITS + 1);
  localparam int unsigned BPS_W       = 6;
  localparam int unsigned CFG_DATA_W  = 6;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned SAMPLE_W    = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_BITS_PER_SAMPLE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PACK_MODE       = 1'd1;

  localparam logic PACK_FILLED = 1'b0;
  localparam logic PACK_PACKED = 1'b1;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Pad for filled mode: WORD_BITS modulo the sample width, indexed by width.
  localparam int unsigned PAD_W = 5;
  localparam logic [PAD_W-1:0] PAD_TABLE [WORD_BITS+1] = '{
    5'd0,  5'd0,  5'd0,  5'd2,  5'd0,  5'd2,  5'd2,  5'd4,  5'd0,
    5'd5,  5'd2,  5'd10, 5'd8,  5'd6,  5'd4,  5'd2,  5'd0,
    5'd15, 5'd14, 5'd13, 5'd12, 5'd11, 5'd10, 5'd9,  5'd8,
    5'd7,  5'd6,  5'd5,  5'd4,  5'd3,  5'd2,  5'd1,  5'd0
  };

  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic                 last_of_run;
  } isw_beat_t;

  // Results of one accepted sample: zero, one or two beats, beat0 first.
  typedef struct packed {
    logic [1:0] count;
    isw_beat_t  beat0;
    isw_beat_t  beat1;
  } isw_push_t;

endpackage

// ===== design/isw_core.sv =====
// Packing datapath: configuration registers, accumulator and free-bit count.
// Produces up to two beats per accepted sample. Depends on isw_pkg.
module isw_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [isw_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [isw_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                accept,
  input  logic [isw_pkg::SAMPLE_W-1:0]        sample,
  input  logic                                line_end,
  output isw_pkg::isw_push_t                  push
);
  import isw_pkg::*;

  logic [BPS_W-1:0]     bits_per_sample;
  logic                 pack_mode;
  logic [WORD_BITS-1:0] accumulator;
  logic [WORD_BITS-1:0] accumulator_next;
  logic [FREE_W-1:0]    bits_free;
  logic [FREE_W-1:0]    bits_free_next;

  logic [FREE_W-1:0]    width;
  logic [PAD_W-1:0]     pad;
  logic [WORD_BITS-1:0] sample_mask;
  logic [WORD_BITS-1:0] sample_masked;
  logic                 fits;
  logic                 flush;
  logic [WORD_BITS-1:0] acc_mid;
  logic [FREE_W-1:0]    free_mid;
  logic [WORD_BITS-1:0] word_full;
  logic [WORD_BITS-1:0] word_flush;

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_per_sample <= BPS_W'(10);
      pack_mode       <= PACK_FILLED;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BITS_PER_SAMPLE: bits_per_sample <= cfg_data[BPS_W-1:0];
        REG_PACK_MODE:       pack_mode       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    // zero acts as one, anything wider than a word acts as a full word
    if (bits_per_sample == '0) begin
      width = FREE_W'(1);
    end else if (FREE_W'(bits_per_sample) > FREE_W'(WORD_BITS)) begin
      width = FREE_W'(WORD_BITS);
    end else begin
      width = FREE_W'(bits_per_sample);
    end

    pad           = (pack_mode == PACK_FILLED) ? PAD_TABLE[width] : '0;
    sample_mask   = {WORD_BITS{1'b1}} >> (FREE_W'(WORD_BITS) - width);
    sample_masked = WORD_BITS'(sample) & sample_mask;
    fits          = (bits_free >= width);

    word_full = accumulator << pad;
    if (fits) begin
      acc_mid  = (accumulator << width) | sample_masked;
      free_mid = bits_free - width;
    end else begin
      acc_mid  = sample_masked;
      free_mid = FREE_W'(WORD_BITS) - width;
    end
    word_flush = acc_mid << pad;
    flush      = line_end && (free_mid != FREE_W'(WORD_BITS));

    push.count = {1'b0, accept & ~fits} + {1'b0, accept & flush};
    if (!fits) begin
      push.beat0 = '{word: word_full, last_of_run: ~flush};
    end else begin
      push.beat0 = '{word: word_flush, last_of_run: 1'b1};
    end
    push.beat1 = '{word: word_flush, last_of_run: 1'b1};

    if (flush) begin
      accumulator_next = '0;
      bits_free_next   = FREE_W'(WORD_BITS);
    end else begin
      accumulator_next = acc_mid;
      bits_free_next   = free_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
      bits_free   <= FREE_W'(WORD_BITS);
    end else if (accept) begin
      accumulator <= accumulator_next;
      bits_free   <= bits_free_next;
    end
  end

  a_free_range: assert property (@(posedge clk) disable iff (rst)
    bits_free <= FREE_W'(WORD_BITS))
    else $error("bits_free above word width");

  a_line_end_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && line_end) |=> (bits_free == FREE_W'(WORD_BITS) && accumulator == '0))
    else $error("word not flushed at line end");

  a_line_end_beat: assert property (@(posedge clk) disable iff (rst)
    (accept && line_end) |-> (push.count != 2'd0))
    else $error("line end produced no beat");

endmodule

// ===== design/isw_queue.sv =====
// Result queue: takes up to two beats per cycle, hands out one per cycle unless stalled.
// Parts the packing datapath from a stalling receiver. Depends on isw_pkg.
module isw_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  isw_pkg::isw_push_t          push,
  output logic                        nearly_full,
  output logic                        valid,
  input  logic                        stall,
  output isw_pkg::isw_beat_t          head
);
  import isw_pkg::*;

  isw_beat_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;
  logic              pop;

  assign valid       = (count != '0);
  assign pop         = valid && !stall;
  assign head        = entries[rd_ptr];
  // room for a two-beat sample must be there before a sample is taken
  assign nearly_full = (count > QCNT_W'(QUEUE_DEPTH - 2));
  assign count_next  = count + QCNT_W'(push.count) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.beat0;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + QPTR_W'(1)] <= push.beat1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (valid && stall) |=> (count >= $past(count)))
    else $error("beat lost while stalled");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (count == '0 && push.count == 2'd0) |=> !valid)
    else $error("beat appeared from nowhere");

endmodule

// ===== design/image_sample_word_packer.sv =====
// Image sample word packer: top level.
// Ties the packing datapath to the result queue. Depends on isw_pkg,
// isw_core and isw_queue.
//
// Usage:
//   Samples enter on sample/line_end with sample_valid; a beat is taken at a
//   clock edge with sample_valid high and sample_stall low. Packed words
//   leave on word/last_of_run with word_valid, taken when word_stall is low.
//   Each sample gives zero, one or two words; last_of_run marks the final
//   word of a sample. Registers are written through cfg_write, cfg_index
//   (0 bits_per_sample, 1 pack_mode) and cfg_data; the user must write them
//   only while idle; the block itself does not enforce this. A taken sample's
//   words are registered in the result queue and leave from its head in order.
//   Throughput: one sample per cycle while each sample gives at most one word and
//   word_stall is low; the four-entry queue drains one word per unstalled cycle.
//   sample_stall rises when fewer than two queue entries are free.
//   Reset empties the queue and the accumulator, sets 10-bit samples and
//   filled mode. A stalled receiver holds its word; the queue fills and
//   then stalls the sample side.
module image_sample_word_packer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [isw_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [isw_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic [isw_pkg::SAMPLE_W-1:0]        sample,
  input  logic                                line_end,
  output logic                                word_valid,
  input  logic                                word_stall,
  output logic [isw_pkg::WORD_BITS-1:0]       word,
  output logic                                last_of_run
);
  import isw_pkg::*;

  isw_push_t push;
  isw_beat_t head;
  logic      accept;

  assign accept = sample_valid && !sample_stall;

  isw_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .sample    (sample),
    .line_end  (line_end),
    .push      (push)
  );

  isw_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .nearly_full (sample_stall),
    .valid       (word_valid),
    .stall       (word_stall),
    .head        (head)
  );

  assign word        = head.word;
  assign last_of_run = head.last_of_run;

endmodule

// ===== tb/image_sample_word_packer_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the image sample word packer: it watches the register port and both
// beat channels, predicts the packed words, and compares them field by field.
// Depends on isw_pkg.
module image_sample_word_packer_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [isw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [isw_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            sample_valid,
  input  logic                            sample_stall,
  input  logic [isw_pkg::SAMPLE_W-1:0]    sample,
  input  logic                            line_end,
  input  logic                            word_valid,
  input  logic                            word_stall,
  input  logic [isw_pkg::WORD_BITS-1:0]   word,
  input  logic                            last_of_run,
  output int unsigned                     words_owed,
  output int unsigned                     mismatch_count
);
  import isw_pkg::*;

  localparam int unsigned RESET_BPS = 10;
  localparam int unsigned TOP_W     = (SAMPLE_W < WORD_BITS) ? SAMPLE_W : WORD_BITS;

  logic [WORD_BITS-1:0] acc;
  int unsigned          bits_free;
  logic [BPS_W-1:0]     bps;
  logic                 mode;
  int unsigned          fails = 0;
  isw_beat_t            expected_words [$];
  isw_beat_t            want;

  // Pad the word on the low end (filled mode only) and queue it.
  task automatic flush_word(input int unsigned w);
    isw_beat_t   b;
    int unsigned pad;
    pad = (mode == PACK_FILLED) ? (WORD_BITS % w) : 0;
    b.word = acc << pad;
    b.last_of_run = 1'b0;
    expected_words.push_back(b);
    acc = '0;
    bits_free = WORD_BITS;
  endtask

  task automatic pack_sample(input logic [SAMPLE_W-1:0] s, input logic le);
    int unsigned         w;
    int unsigned         before_cnt;
    logic [SAMPLE_W-1:0] smask;
    isw_beat_t           b;
    w = (bps == 0) ? 1 : (bps > TOP_W) ? TOP_W : bps;
    before_cnt = expected_words.size();
    smask = {SAMPLE_W{1'b1}} >> (SAMPLE_W - w);
    if (bits_free < w) flush_word(w);
    acc = (acc << w) | WORD_BITS'(s & smask);
    bits_free -= w;
    if (le && bits_free != WORD_BITS) flush_word(w);
    // mark the final word caused by this sample
    if (expected_words.size() > before_cnt) begin
      b = expected_words.pop_back();
      b.last_of_run = 1'b1;
      expected_words.push_back(b);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      acc = '0;
      bits_free = WORD_BITS;
      bps = BPS_W'(RESET_BPS);
      mode = PACK_FILLED;
      expected_words.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_BITS_PER_SAMPLE) bps = cfg_data[BPS_W-1:0];
        else if (cfg_index == REG_PACK_MODE) mode = cfg_data[0];
      end
      // an output beat taken now always comes from an earlier sample
      if (word_valid && !word_stall) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word beat: word %h last_of_run %b", word, last_of_run);
          fails++;
        end else begin
          want = expected_words.pop_front();
          if (word !== want.word) begin
            $error("word: expected %h, got %h", want.word, word);
            fails++;
          end
          if (last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %b, got %b", want.last_of_run, last_of_run);
            fails++;
          end
        end
      end
      if (sample_valid && !sample_stall) pack_sample(sample, line_end);
    end
    words_owed <= expected_words.size();
    mismatch_count <= fails;
  end

endmodule

// ===== tb/tb_image_sample_word_packer.sv =====
`timescale 1ns / 1ps
// Testbench top for the image sample word packer: clock, reset, sample and stall
// stimulus, register settings per phase, watchdog and verdict.
// Depends on isw_pkg, image_sample_word_packer and image_sample_word_packer_checker.
module tb_image_sample_word_packer;
  import isw_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned NUM_FIXED      = 15;
  localparam int unsigned NUM_PHASES     = 18;
  localparam int unsigned FIRST_ITEMS    = 150;
  localparam int unsigned PHASE_ITEMS    = 105;
  localparam int unsigned NUM_DIRECTED   = 16;

  // Phase 0 runs on the reset settings; the rest cover width extremes and both modes.
  localparam logic [BPS_W-1:0] FIXED_BPS [NUM_FIXED] = '{
    6'd10, 6'd1, 6'd32, 6'd0, 6'd63, 6'd33, 6'd10, 6'd3,
    6'd7, 6'd11, 6'd17, 6'd31, 6'd5, 6'd32, 6'd1
  };
  localparam logic FIXED_MODE [NUM_FIXED] = '{
    PACK_FILLED, PACK_FILLED, PACK_FILLED, PACK_PACKED, PACK_FILLED,
    PACK_PACKED, PACK_PACKED, PACK_FILLED, PACK_PACKED, PACK_FILLED,
    PACK_FILLED, PACK_PACKED, PACK_FILLED, PACK_PACKED, PACK_PACKED
  };

  // {line_end, sample}: masked bits, a word overflow together with a line flush,
  // single-sample lines and word overflows without a line end, at 10 bits per sample.
  localparam logic [SAMPLE_W:0] DIRECTED [NUM_DIRECTED] = '{
    {1'b0, 32'h000003FF}, {1'b0, 32'hFFFFFFFF}, {1'b0, 32'h00000000},
    {1'b1, 32'hAAAAAAAA}, {1'b1, 32'h55555555}, {1'b0, 32'h12345678},
    {1'b0, 32'h9ABCDEF0}, {1'b0, 32'hFFFFFC00}, {1'b0, 32'h000003FF},
    {1'b1, 32'h80000000}, {1'b1, 32'h00000000}, {1'b1, 32'hFFFFFFFF},
    {1'b0, 32'h00000001}, {1'b0, 32'h00000200}, {1'b0, 32'h7FFFFFFF},
    {1'b1, 32'h000002AA}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   sample_valid = 1'b0;
  logic                   sample_stall;
  logic [SAMPLE_W-1:0]    sample = '0;
  logic                   line_end = 1'b0;
  logic                   word_valid;
  logic                   word_stall = 1'b0;
  logic [WORD_BITS-1:0]   word;
  logic                   last_of_run;
  int unsigned            words_owed;
  int unsigned            mismatch_count;
  int unsigned            quiet_cycles = 0;
  bit                     sender_eager = 1'b0;

  image_sample_word_packer dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .line_end     (line_end),
    .word_valid   (word_valid),
    .word_stall   (word_stall),
    .word         (word),
    .last_of_run  (last_of_run)
  );

  image_sample_word_packer_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .sample_valid   (sample_valid),
    .sample_stall   (sample_stall),
    .sample         (sample),
    .line_end       (line_end),
    .word_valid     (word_valid),
    .word_stall     (word_stall),
    .word           (word),
    .last_of_run    (last_of_run),
    .words_owed     (words_owed),
    .mismatch_count (mismatch_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Mostly short gaps, a few long ones.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Call at a rising edge; returns at the edge where the beat is taken.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic le);
    int unsigned gap;
    gap = sender_eager ? 0 : idle_len();
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= s;
    line_end <= le;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Let the checker's count catch up with the last beat taken, then drain.
  task automatic wait_drained();
    repeat (2) @(posedge clk);
    while (words_owed != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned          ph;
    int unsigned          i;
    int unsigned          n_items;
    int unsigned          le_rate;
    int unsigned          r;
    logic [BPS_W-1:0]     bps;
    logic                 mode;
    logic [SAMPLE_W-1:0]  s;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 0) begin
        for (i = 0; i < NUM_DIRECTED; i++)
          send_sample(DIRECTED[i][SAMPLE_W-1:0], DIRECTED[i][SAMPLE_W]);
        n_items = FIRST_ITEMS;
      end else begin
        sample_valid <= 1'b0;
        wait_drained();
        // a sample that gives no word may still be in flight
        repeat (4) @(posedge clk);
        if (ph < NUM_FIXED) begin
          bps = FIXED_BPS[ph];
          mode = FIXED_MODE[ph];
        end else begin
          bps = BPS_W'($urandom_range(0, 63));
          mode = 1'($urandom_range(0, 1));
        end
        write_reg(REG_BITS_PER_SAMPLE, CFG_DATA_W'(bps));
        write_reg(REG_PACK_MODE, CFG_DATA_W'(mode));
        n_items = PHASE_ITEMS;
      end
      sender_eager = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 2))
        0: le_rate = 2;
        1: le_rate = 8;
        default: le_rate = 40;
      endcase
      repeat (n_items) begin
        r = $urandom_range(0, 9);
        s = (r == 0) ? '0 : (r == 1) ? '1 : $urandom;
        send_sample(s, $urandom_range(0, le_rate - 1) == 0);
      end
    end
    sample_valid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb_image_sample_word_packer: clean");
    else
      $display("tb_image_sample_word_packer: errors");
    $finish;
  end

  // Output side: one long hold early on so the queue fills and backs up the input,
  // then random stalls with occasional stall-free stretches.
  initial begin
    int unsigned st;
    int unsigned run;
    @(posedge clk);
    while (rst) @(posedge clk);
    repeat ($urandom_range(30, 80)) @(posedge clk);
    word_stall <= 1'b1;
    repeat (300) @(posedge clk);
    forever begin
      word_stall <= 1'b0;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 12);
      repeat (run) @(posedge clk);
      st = idle_len();
      if (st > 0) begin
        word_stall <= 1'b1;
        repeat (st) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_write || (sample_valid && !sample_stall) || (word_valid && !word_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb_image_sample_word_packer: errors");
      $finish;
    end
  end

endmodule
